FILE: hdl/swrl_pkg.sv
// Shared types and constants for the sliding window rate limiter.
package swrl_pkg;

    localparam int SLOTS_DEFAULT = 100;
    localparam int OUT_DEPTH     = 8;
    localparam int OUT_CW        = $clog2(OUT_DEPTH + 1);
    localparam int WIN_W         = 39;

    localparam logic [31:0]      CNT_MAX = 32'hFFFF_FFFF;
    localparam logic [WIN_W-1:0] WIN_MAX = 39'h7F_FFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_REQUEST = 2'd1,
        CMD_OPEN    = 2'd2,
        CMD_CLOSE   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic             accepted;
        logic [63:0]      commands_total;
        logic [63:0]      connections_total;
        logic [31:0]      live_clients;
        logic [WIN_W-1:0] window_total;
    } res_t;

endpackage

FILE: hdl/sliding_window_rate_limiter_core.sv
// Top level of the sliding window rate limiter.
//
// Input channel (in_valid/in_ready): one event per item, command plus
// tick_seconds. Tick selects slot tick_seconds mod SLOTS as current and
// clears it; request is counted against rate_limit; open and close adjust
// the client count. Output channel (out_valid/out_ready): one result item
// per event, in order, holding accepted and the totals after the event.
// rate_limit is written through cfg_write_en/cfg_write_data; the user must
// write it only while idle; the block does not enforce this. Throughput:
// one item per cycle while in_ready is high. An item passes two modulo
// stages, a slot memory read, then the slot counter read-modify-write.
// Up to OUT_DEPTH items may be outstanding; when the receiver stalls the
// result queue fills and in_ready drops until results are taken.
// Reset: all totals clear, then a clearing pass zeroes the slot memory
// one entry per cycle over all SLOTS entries, during which in_ready is low.
module sliding_window_rate_limiter_core
    import swrl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       command,
    input  logic [31:0]      tick_seconds,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             accepted,
    output logic [63:0]      commands_total,
    output logic [63:0]      connections_total,
    output logic [31:0]      live_clients,
    output logic [WIN_W-1:0] window_total,
    input  logic             cfg_write_en,
    input  logic [31:0]      cfg_write_data
);

    localparam int SW = $clog2(SLOTS);

    logic [31:0]     rate_limit_reg;
    logic [OUT_CW-1:0] outstanding_reg;
    logic            in_fire;
    logic            out_fire;

    logic            mod_valid;
    cmd_t            mod_cmd;
    logic [SW-1:0]   mod_slot;

    logic            res_valid;
    res_t            res;
    res_t            out_data;
    logic            clr_busy;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = !clr_busy && (outstanding_reg < OUT_CW'(OUT_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_limit_reg  <= '0;
            outstanding_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                rate_limit_reg <= cfg_write_data;
            end
            outstanding_reg <= outstanding_reg + OUT_CW'(in_fire) - OUT_CW'(out_fire);
        end
    end

    swrl_mod_unit #(
        .SLOTS (SLOTS)
    ) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_fire),
        .in_cmd    (cmd_t'(command)),
        .in_secs   (tick_seconds),
        .out_valid (mod_valid),
        .out_cmd   (mod_cmd),
        .out_slot  (mod_slot)
    );

    swrl_counter_core #(
        .SLOTS (SLOTS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (mod_valid),
        .in_cmd     (mod_cmd),
        .in_slot    (mod_slot),
        .rate_limit (rate_limit_reg),
        .res_valid  (res_valid),
        .res        (res),
        .clr_busy   (clr_busy)
    );

    swrl_out_fifo #(
        .DEPTH (OUT_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (out_data)
    );

    assign accepted          = out_data.accepted;
    assign commands_total    = out_data.commands_total;
    assign connections_total = out_data.connections_total;
    assign live_clients      = out_data.live_clients;
    assign window_total      = out_data.window_total;

`ifndef NO_ASSERTIONS
    a_outstanding_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= OUT_CW'(OUT_DEPTH))
        else $error("outstanding item count out of bound");
`endif

endmodule

FILE: hdl/swrl_mod_unit.sv
// Two-stage reciprocal pipeline that reduces the tick time modulo SLOTS.
module swrl_mod_unit
    import swrl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  cmd_t                     in_cmd,
    input  logic [31:0]              in_secs,
    output logic                     out_valid,
    output cmd_t                     out_cmd,
    output logic [$clog2(SLOTS)-1:0] out_slot
);

    localparam int SW = $clog2(SLOTS);
    localparam int K  = 32 + SW;
    localparam logic [32:0] RECIP = 33'((65'(1) << K) / SLOTS);

    logic        valid_a_reg;
    cmd_t        cmd_a_reg;
    logic [31:0] secs_a_reg;
    logic [64:0] prod_a_reg;
    logic [64:0] prod_next;

    logic        valid_b_reg;
    cmd_t        cmd_b_reg;
    logic [31:0] secs_b_reg;
    logic [31:0] qd_b_reg;
    logic [31:0] q_a;
    logic [31:0] qd_next;

    logic [31:0] rem;
    logic [31:0] rem_sub;

    assign prod_next = {33'd0, in_secs} * {32'd0, RECIP};
    assign q_a       = 32'(prod_a_reg >> K);
    assign qd_next   = 32'({32'd0, q_a} * 64'(SLOTS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_a_reg  <= in_cmd;
        secs_a_reg <= in_secs;
        prod_a_reg <= prod_next;
        cmd_b_reg  <= cmd_a_reg;
        secs_b_reg <= secs_a_reg;
        qd_b_reg   <= qd_next;
    end

    // Correct the quotient estimate, which may be one low
    assign rem     = secs_b_reg - qd_b_reg;
    assign rem_sub = rem - 32'(SLOTS);

    assign out_valid = valid_b_reg;
    assign out_cmd   = cmd_b_reg;
    assign out_slot  = (rem >= 32'(SLOTS)) ? rem_sub[SW-1:0] : rem[SW-1:0];

`ifndef NO_ASSERTIONS
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_cmd == CMD_TICK) |-> (32'(out_slot) < 32'(SLOTS)))
        else $error("tick slot out of range");
`endif

endmodule

FILE: hdl/swrl_counter_core.sv
// Slot counter memory with read-modify-write, forwarding and running totals.
module swrl_counter_core
    import swrl_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  cmd_t                     in_cmd,
    input  logic [$clog2(SLOTS)-1:0] in_slot,
    input  logic [31:0]              rate_limit,
    output logic                     res_valid,
    output res_t                     res,
    output logic                     clr_busy
);

    localparam int SW = $clog2(SLOTS);

    logic [31:0]      mem [SLOTS];
    logic [31:0]      rdata_reg;

    logic [SW-1:0]    cur_slot_reg;
    logic [SW-1:0]    rd_addr;

    logic             valid_c_reg;
    cmd_t             cmd_c_reg;
    logic [SW-1:0]    addr_c_reg;

    logic             fwd_valid_reg;
    logic [SW-1:0]    fwd_addr_reg;
    logic [31:0]      fwd_data_reg;

    logic             clr_busy_reg;
    logic [SW-1:0]    clr_idx_reg;

    logic [WIN_W-1:0] win_reg;
    logic [WIN_W-1:0] win_next;
    logic [63:0]      req_reg;
    logic [63:0]      req_next;
    logic [63:0]      open_reg;
    logic [63:0]      open_next;
    logic [31:0]      client_reg;
    logic [31:0]      client_next;

    logic [31:0]      cur_cnt;
    logic             refuse;
    logic             accepted;
    logic             slot_we;
    logic [31:0]      slot_wdata;
    logic             mem_we;
    logic [SW-1:0]    mem_waddr;
    logic [31:0]      mem_wdata;

    // Read stage
    assign rd_addr = (in_cmd == CMD_TICK) ? in_slot : cur_slot_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_slot_reg  <= '0;
            valid_c_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_idx_reg   <= '0;
            win_reg       <= '0;
            req_reg       <= '0;
            open_reg      <= '0;
            client_reg    <= '0;
        end
        else
        begin
            if (in_valid && (in_cmd == CMD_TICK))
            begin
                cur_slot_reg <= in_slot;
            end
            valid_c_reg   <= in_valid;
            fwd_valid_reg <= mem_we;
            if (clr_busy_reg)
            begin
                clr_idx_reg <= clr_idx_reg + SW'(1);
                if (clr_idx_reg == SW'(SLOTS - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            win_reg    <= win_next;
            req_reg    <= req_next;
            open_reg   <= open_next;
            client_reg <= client_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_c_reg    <= in_cmd;
        addr_c_reg   <= rd_addr;
        fwd_addr_reg <= mem_waddr;
        fwd_data_reg <= mem_wdata;
    end

    // Modify stage: take the write of the previous cycle over the stale read
    assign cur_cnt = (fwd_valid_reg && (fwd_addr_reg == addr_c_reg)) ? fwd_data_reg
                                                                      : rdata_reg;
    assign refuse  = (rate_limit != 32'd0) && (cur_cnt > rate_limit);

    always_comb
    begin
        win_next    = win_reg;
        req_next    = req_reg;
        open_next   = open_reg;
        client_next = client_reg;
        accepted    = 1'b1;
        slot_we     = 1'b0;
        slot_wdata  = cur_cnt;
        if (valid_c_reg)
        begin
            case (cmd_c_reg)
                CMD_TICK:
                begin
                    win_next   = (win_reg >= {7'd0, cur_cnt}) ? win_reg - {7'd0, cur_cnt}
                                                              : '0;
                    slot_we    = 1'b1;
                    slot_wdata = 32'd0;
                end
                CMD_REQUEST:
                begin
                    if (refuse)
                    begin
                        accepted = 1'b0;
                    end
                    else
                    begin
                        req_next = req_reg + 64'd1;
                        if ((cur_cnt != CNT_MAX) && (win_reg != WIN_MAX))
                        begin
                            slot_we    = 1'b1;
                            slot_wdata = cur_cnt + 32'd1;
                            win_next   = win_reg + WIN_W'(1);
                        end
                    end
                end
                CMD_OPEN:
                begin
                    open_next = open_reg + 64'd1;
                    if (client_reg != CNT_MAX)
                    begin
                        client_next = client_reg + 32'd1;
                    end
                end
                default:
                begin
                    if (client_reg != 32'd0)
                    begin
                        client_next = client_reg - 32'd1;
                    end
                end
            endcase
        end
    end

    assign mem_we    = clr_busy_reg || slot_we;
    assign mem_waddr = clr_busy_reg ? clr_idx_reg : addr_c_reg;
    assign mem_wdata = clr_busy_reg ? 32'd0 : slot_wdata;

    assign res_valid             = valid_c_reg;
    assign res.accepted          = accepted;
    assign res.commands_total    = req_next;
    assign res.connections_total = open_next;
    assign res.live_clients      = client_next;
    assign res.window_total      = win_next;
    assign clr_busy              = clr_busy_reg;

`ifndef NO_ASSERTIONS
    a_no_item_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !valid_c_reg && !in_valid)
        else $error("item in flight during clearing pass");

    a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg && (cmd_c_reg == CMD_REQUEST) && refuse
        |=> $stable(win_reg) && $stable(req_reg))
        else $error("refused request changed totals");

    a_tick_clears: assert property (@(posedge clk) disable iff (!rst_n)
        valid_c_reg && (cmd_c_reg == CMD_TICK) && !clr_busy_reg
        |-> mem_we && (mem_wdata == 32'd0))
        else $error("tick did not clear its slot");
`endif

endmodule

FILE: hdl/swrl_out_fifo.sv
// Result queue that parts the pipeline from the output handshake.
module swrl_out_fifo
    import swrl_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  res_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output res_t pop_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    res_t          data_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = (count_reg != '0);
    assign pop_data  = data_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CW'(DEPTH)) || pop)
        else $error("result queue overflow");
`endif

endmodule

FILE: test/tb_sliding_window_rate_limiter_core.sv
// Self-checking testbench for the sliding window rate limiter core, with an in-bench predictor.
module tb_sliding_window_rate_limiter_core;
    import swrl_pkg::*;

    localparam int SLOTS    = SLOTS_DEFAULT;
    localparam int LATENCY  = 3;
    localparam int PHASES   = 9;
    localparam int PHASE_N  = 200;
    localparam int IDLE_PCT = 37;

    typedef struct {
        cmd_t        cmd;
        logic [31:0] secs;
    } limiter_op_t;

    logic             clk            = 1'b0;
    logic             rst_n          = 1'b0;
    logic             in_valid       = 1'b0;
    logic             in_ready;
    logic [1:0]       command        = '0;
    logic [31:0]      tick_seconds   = '0;
    logic             out_valid;
    logic             out_ready      = 1'b0;
    logic             accepted;
    logic [63:0]      commands_total;
    logic [63:0]      connections_total;
    logic [31:0]      live_clients;
    logic [WIN_W-1:0] window_total;
    logic             cfg_write_en   = 1'b0;
    logic [31:0]      cfg_write_data = '0;

    limiter_op_t pending_ops[$];
    res_t        expected_results[$];
    bit          in_busy  = 1'b0;
    bit          hold_in  = 1'b0;
    int          idle_pct = IDLE_PCT;
    int          errors   = 0;

    logic [31:0]      slot_count [SLOTS] = '{default: '0};
    int unsigned      cur_slot   = 0;
    logic [WIN_W-1:0] win_sum    = '0;
    logic [63:0]      cmd_total  = '0;
    logic [63:0]      conn_total = '0;
    logic [31:0]      clients    = '0;
    logic [31:0]      limit_q    = '0;

    sliding_window_rate_limiter_core #(
        .SLOTS(SLOTS)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .tick_seconds     (tick_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .accepted         (accepted),
        .commands_total   (commands_total),
        .connections_total(connections_total),
        .live_clients     (live_clients),
        .window_total     (window_total),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data)
    );

    initial
    begin
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #3_200_000;
        $display("simulation failed");
        $finish;
    end

    task automatic predict_limiter(input logic [1:0] cmd_bits, input logic [31:0] secs);
        res_t        r;
        logic [31:0] cnt;
        int unsigned s;
        r.accepted = 1'b1;
        case (cmd_t'(cmd_bits))
            CMD_TICK:
            begin
                s = secs % 32'(SLOTS);
                cnt = slot_count[s];
                cur_slot = s;
                win_sum = (win_sum >= WIN_W'(cnt)) ? win_sum - WIN_W'(cnt) : '0;
                slot_count[s] = '0;
            end
            CMD_REQUEST:
            begin
                cnt = slot_count[cur_slot];
                if (limit_q != '0 && cnt > limit_q)
                begin
                    r.accepted = 1'b0;
                end
                else
                begin
                    cmd_total = cmd_total + 64'd1;
                    if (cnt != CNT_MAX && win_sum != WIN_MAX)
                    begin
                        slot_count[cur_slot] = cnt + 32'd1;
                        win_sum = win_sum + WIN_W'(1);
                    end
                end
            end
            CMD_OPEN:
            begin
                if (clients != CNT_MAX)
                    clients = clients + 32'd1;
                conn_total = conn_total + 64'd1;
            end
            default:
            begin
                if (clients != '0)
                    clients = clients - 32'd1;
            end
        endcase
        r.commands_total    = cmd_total;
        r.connections_total = conn_total;
        r.live_clients      = clients;
        r.window_total      = win_sum;
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch in %s: expected %0h, got %0h", name, want, got);
        end
    endtask

    // drive inputs at the falling edge
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_busy)
        begin
            if (pending_ops.size() != 0 && !hold_in && $urandom_range(99) >= idle_pct)
            begin
                in_valid     <= 1'b1;
                command      <= pending_ops[0].cmd;
                tick_seconds <= pending_ops[0].secs;
                in_busy = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // sample at the rising edge
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cfg_write_en)
                limit_q = cfg_write_data;
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("result item with no item pending");
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("accepted", 64'(want.accepted), 64'(accepted));
                    compare_field("commands_total", want.commands_total, commands_total);
                    compare_field("connections_total", want.connections_total,
                                  connections_total);
                    compare_field("live_clients", 64'(want.live_clients), 64'(live_clients));
                    compare_field("window_total", 64'(want.window_total), 64'(window_total));
                end
            end
            if (in_valid && in_ready)
            begin
                predict_limiter(command, tick_seconds);
                void'(pending_ops.pop_front());
                in_busy = 1'b0;
            end
        end
    end

    task automatic push_op(input cmd_t cmd, input logic [31:0] secs);
        limiter_op_t op;
        op.cmd  = cmd;
        op.secs = secs;
        pending_ops.push_back(op);
    endtask

    task automatic drain();
        while (pending_ops.size() != 0 || in_busy || expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_limit(input logic [31:0] value);
        drain();
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] phase_limit [PHASES];
        logic [31:0] sim_secs;
        int          tick_pct;
        int          r;
        phase_limit = '{32'd2, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd0, 32'd3, 32'd0, 32'd2};
        phase_limit[4] = $urandom_range(6, 3);
        phase_limit[5] = $urandom();
        sim_secs = $urandom();

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);

        write_limit(32'd0);
        push_op(CMD_REQUEST, 32'hFFFF_FFFF);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_CLOSE, 32'd0);
        push_op(CMD_CLOSE, 32'hFFFF_FFFF);
        push_op(CMD_OPEN, 32'd0);
        push_op(CMD_OPEN, 32'd0);
        push_op(CMD_OPEN, 32'd0);
        push_op(CMD_CLOSE, 32'd0);
        push_op(CMD_TICK, 32'd0);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_TICK, 32'hFFFF_FFFF);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_TICK, 32'd99);
        push_op(CMD_TICK, 32'd100);
        push_op(CMD_TICK, 32'h8000_0000);

        write_limit(32'd1);
        push_op(CMD_TICK, 32'd5);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_REQUEST, 32'd0);
        push_op(CMD_OPEN, 32'd0);
        push_op(CMD_CLOSE, 32'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p]);
            idle_pct = (p == 2) ? 0 : IDLE_PCT;
            tick_pct = $urandom_range(25, 5);
            for (int i = 0; i < PHASE_N; i++)
            begin
                r = $urandom_range(99);
                if (r < tick_pct)
                begin
                    if ($urandom_range(99) < 70)
                    begin
                        sim_secs = sim_secs + 32'd1;
                        push_op(CMD_TICK, sim_secs);
                    end
                    else
                    begin
                        push_op(CMD_TICK, $urandom());
                    end
                end
                else if (r < 70)
                    push_op(CMD_REQUEST, $urandom());
                else if (r < 85)
                    push_op(CMD_OPEN, $urandom());
                else
                    push_op(CMD_CLOSE, $urandom());
            end
            if (p == 4)
            begin
                while (pending_ops.size() > PHASE_N / 2)
                    @(posedge clk);
                hold_in = 1'b1;
                while (in_busy || expected_results.size() != 0)
                    @(posedge clk);
                hold_in = 1'b0;
            end
        end

        drain();
        if (errors == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
